FILE: src/bedc_pkg.sv
// Shared types and constants for the button edge and double-click detector.
`default_nettype none

package bedc_pkg;

    localparam int POLL_BITS = 8;
    localparam int TIME_BITS = 32;

    typedef logic [1:0] click_count_t;
    typedef logic [TIME_BITS-1:0] time_ms_t;
    typedef logic [POLL_BITS-1:0] poll_mask_t;

    localparam click_count_t CLICK_NONE = 2'd0;
    localparam click_count_t CLICK_ONE  = 2'd1;
    localparam click_count_t CLICK_TWO  = 2'd2;

    localparam time_ms_t WINDOW_RESET = 32'd500;

    // What one lane found for the current poll
    typedef struct packed {
        logic down;
        logic up;
        logic held;
        logic dbl;
    } lane_flags_t;

endpackage

`default_nettype wire

FILE: src/bedc_lane.sv
// One button lane: edge detection, click count and first-click timestamp.
`default_nettype none

module bedc_lane (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    adv,
    input  wire                    btn_pressed,
    input  wire bedc_pkg::time_ms_t now_ms,
    input  wire bedc_pkg::time_ms_t window,
    output bedc_pkg::lane_flags_t  flags
);
    import bedc_pkg::*;

    logic         prev_reg;
    click_count_t count_reg;
    click_count_t count_next;
    time_ms_t     first_reg;
    time_ms_t     first_next;
    time_ms_t     elapsed;
    logic         expired;
    logic         in_window;
    click_count_t count_dn;

    assign elapsed   = now_ms - first_reg;
    assign expired   = (elapsed >= window);
    assign in_window = (elapsed <= window);

    always_comb
    begin
        flags      = '0;
        count_next = count_reg;
        first_next = first_reg;
        count_dn   = count_reg;
        if (!prev_reg && btn_pressed)
        begin
            flags.down = 1'b1;
            // drop a stale first click before counting this press
            if (count_reg == CLICK_ONE && expired)
                count_dn = CLICK_NONE;
            if (count_dn < CLICK_TWO)
                count_next = count_dn + 2'd1;
            else
                count_next = count_dn;
            if (count_next == CLICK_ONE)
                first_next = now_ms;
        end
        else if (prev_reg && !btn_pressed)
        begin
            if (count_reg == CLICK_ONE)
            begin
                if (expired)
                    count_next = CLICK_NONE;
            end
            else if (count_reg == CLICK_TWO)
            begin
                flags.dbl  = in_window;
                count_next = CLICK_NONE;
            end
            flags.up = !flags.dbl;
        end
        else if (prev_reg && btn_pressed)
        begin
            flags.held = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            count_reg <= CLICK_NONE;
            first_reg <= '0;
        end
        else if (adv)
        begin
            prev_reg  <= btn_pressed;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("click count out of range");

    a_dbl_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv && flags.dbl |=> count_reg == CLICK_NONE)
        else $error("count not cleared after double click");

endmodule

`default_nettype wire

FILE: src/bedc_merge.sv
// Merge stage: gathers lane flags into masks and holds the result register.
`default_nettype none

module bedc_merge #(
    parameter int NUM_BUTTONS = 8
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     adv,
    input  wire bedc_pkg::lane_flags_t [NUM_BUTTONS-1:0] lane_flags,
    input  wire                                     out_ready,
    output logic                                    out_valid,
    output bedc_pkg::poll_mask_t                    down_mask,
    output bedc_pkg::poll_mask_t                    up_mask,
    output bedc_pkg::poll_mask_t                    held_mask,
    output bedc_pkg::poll_mask_t                    double_click_mask
);
    import bedc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    poll_mask_t down_next;
    poll_mask_t up_next;
    poll_mask_t held_next;
    poll_mask_t dbl_next;
    poll_mask_t down_reg;
    poll_mask_t up_reg;
    poll_mask_t held_reg;
    poll_mask_t dbl_reg;

    genvar gi;
    generate
        for (gi = 0; gi < POLL_BITS; gi++)
        begin : g_bit
            if (gi < NUM_BUTTONS)
            begin : g_lane
                assign down_next[gi] = lane_flags[gi].down;
                assign up_next[gi]   = lane_flags[gi].up;
                assign held_next[gi] = lane_flags[gi].held;
                assign dbl_next[gi]  = lane_flags[gi].dbl;
            end
            else
            begin : g_none
                assign down_next[gi] = 1'b0;
                assign up_next[gi]   = 1'b0;
                assign held_next[gi] = 1'b0;
                assign dbl_next[gi]  = 1'b0;
            end
        end
    endgenerate

    assign valid_next = adv ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            down_reg <= down_next;
            up_reg   <= up_next;
            held_reg <= held_next;
            dbl_reg  <= dbl_next;
        end
    end

    assign out_valid         = valid_reg;
    assign down_mask         = down_reg;
    assign up_mask           = up_reg;
    assign held_mask         = held_reg;
    assign double_click_mask = dbl_reg;

    a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> valid_reg)
        else $error("accepted poll produced no result");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((down_reg & (up_reg | held_reg | dbl_reg)) == '0)
                      && ((up_reg & (held_reg | dbl_reg)) == '0)
                      && ((held_reg & dbl_reg) == '0))
        else $error("button reported in more than one class");

endmodule

`default_nettype wire

FILE: src/button_edge_double_click_detector.sv
// Button edge and double-click detector: top level with lanes and merge stage.
//
// Usage: each input transaction (in_valid/in_ready) carries one poll: the
// pressed bits of up to eight buttons and a millisecond timestamp now_ms.
// Each output transaction (out_valid/out_ready) carries down, up, held and
// double-click masks for that poll, one result per poll, in order.
// The window register is written through cfg_valid/cfg_ready/cfg_data; the
// port is always ready. Write it only while no poll is in flight.
// out_valid rises in the cycle after input acceptance. Throughput: one poll
// per cycle while the receiver takes each result; every button lane does
// its 32-bit elapsed subtract and window compare in the same cycle as the
// accept, then the merge stage registers the masks.
// Reset clears the previous pressed state, every click count and start time,
// and loads the window with 500 ms. No output is valid after reset.
// When the receiver stalls, the result register holds and in_ready drops
// until the result is taken; a new poll is accepted in the cycle the
// waiting result leaves.
`default_nettype none

module button_edge_double_click_detector #(
    parameter int NUM_BUTTONS = 8
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire bedc_pkg::time_ms_t   cfg_data,
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire bedc_pkg::poll_mask_t pressed,
    input  wire bedc_pkg::time_ms_t   now_ms,
    output logic                      out_valid,
    input  wire                       out_ready,
    output bedc_pkg::poll_mask_t      down_mask,
    output bedc_pkg::poll_mask_t      up_mask,
    output bedc_pkg::poll_mask_t      held_mask,
    output bedc_pkg::poll_mask_t      double_click_mask
);
    import bedc_pkg::*;

    time_ms_t                      window_reg;
    logic                          adv;
    logic [NUM_BUTTONS-1:0]        lane_pressed;
    lane_flags_t [NUM_BUTTONS-1:0] lane_flags;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_RESET;
        else if (cfg_valid && cfg_ready)
            window_reg <= cfg_data;
    end

    assign in_ready = !out_valid || out_ready;
    assign adv      = in_valid && in_ready;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_BUTTONS; gi++)
        begin : g_lane
            // buttons past the poll width always read as released
            if (gi < POLL_BITS)
            begin : g_in
                assign lane_pressed[gi] = pressed[gi];
            end
            else
            begin : g_off
                assign lane_pressed[gi] = 1'b0;
            end

            bedc_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .adv         (adv),
                .btn_pressed (lane_pressed[gi]),
                .now_ms      (now_ms),
                .window      (window_reg),
                .flags       (lane_flags[gi])
            );
        end
    endgenerate

    bedc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .lane_flags        (lane_flags),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .down_mask         (down_mask),
        .up_mask           (up_mask),
        .held_mask         (held_mask),
        .double_click_mask (double_click_mask)
    );

endmodule

`default_nettype wire

FILE: bench/tb_button_edge_double_click_detector.sv
// Testbench for the button edge and double-click detector: directed and random polls.
`timescale 1ns / 1ps

module tb_button_edge_double_click_detector;
    import bedc_pkg::*;

    localparam int NUM_LANES   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        poll_mask_t down;
        poll_mask_t up;
        poll_mask_t held;
        poll_mask_t dbl;
    } poll_masks_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    time_ms_t   cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    poll_mask_t pressed = '0;
    time_ms_t   now_ms = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    poll_mask_t down_mask;
    poll_mask_t up_mask;
    poll_mask_t held_mask;
    poll_mask_t double_click_mask;

    // Shadow of the detector's state
    poll_mask_t   last_pressed = '0;
    click_count_t clicks[NUM_LANES];
    time_ms_t     first_press_ms[NUM_LANES];
    time_ms_t     window_ms = WINDOW_RESET;

    poll_masks_t  expected_masks_q[$];

    int unsigned cycle_count = 0;
    int unsigned polls_sent = 0;
    int unsigned masks_checked = 0;
    int unsigned doubles_seen = 0;
    int unsigned window_writes = 0;
    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;

    // Stimulus state for the random part
    poll_mask_t stim_pressed = '0;
    time_ms_t   stim_now = '0;

    button_edge_double_click_detector #(
        .NUM_BUTTONS(NUM_LANES)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pressed          (pressed),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .down_mask        (down_mask),
        .up_mask          (up_mask),
        .held_mask        (held_mask),
        .double_click_mask(double_click_mask)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_masks_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic poll_masks_t predict_poll(poll_mask_t cur, time_ms_t now);
        poll_masks_t r;
        time_ms_t    elapsed;
        logic        is_double;
        r = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            elapsed = now - first_press_ms[i];
            if (!last_pressed[i] && cur[i])
            begin
                r.down[i] = 1'b1;
                if (clicks[i] == CLICK_ONE && elapsed >= window_ms)
                    clicks[i] = CLICK_NONE;
                if (clicks[i] == CLICK_NONE)
                    clicks[i] = CLICK_ONE;
                else if (clicks[i] == CLICK_ONE)
                    clicks[i] = CLICK_TWO;
                if (clicks[i] == CLICK_ONE)
                    first_press_ms[i] = now;
            end
            else if (last_pressed[i] && !cur[i])
            begin
                is_double = 1'b0;
                if (clicks[i] == CLICK_ONE)
                begin
                    if (elapsed >= window_ms)
                        clicks[i] = CLICK_NONE;
                end
                else if (clicks[i] == CLICK_TWO)
                begin
                    is_double = (elapsed <= window_ms);
                    clicks[i] = CLICK_NONE;
                end
                if (is_double)
                    r.dbl[i] = 1'b1;
                else
                    r.up[i] = 1'b1;
            end
            else if (last_pressed[i] && cur[i])
            begin
                r.held[i] = 1'b1;
            end
        end
        last_pressed = cur;
        return r;
    endfunction

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin
        poll_masks_t want;
        poll_masks_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{down_mask, up_mask, held_mask, double_click_mask};
            if (expected_masks_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: down=%h up=%h held=%h dbl=%h",
                             got.down, got.up, got.held, got.dbl);
            end
            else
            begin
                want = expected_masks_q.pop_front();
                masks_checked++;
                if (want.dbl != 0)
                    doubles_seen++;
                if (got.down != want.down || got.up != want.up ||
                    got.held != want.held || got.dbl != want.dbl)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch at result %0d: ",
                                  "exp down=%h up=%h held=%h dbl=%h, ",
                                  "got down=%h up=%h held=%h dbl=%h"},
                                 masks_checked, want.down, want.up, want.held,
                                 want.dbl, got.down, got.up, got.held, got.dbl);
                end
            end
        end
        // Change the stall pattern now and then
        if (cycle_count % 150 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 6);
            default: out_ready <= ((cycle_count % 7) >= 3);
        endcase
    end

    // Send one poll, record its expected masks, then maybe idle between bursts
    task automatic send_poll(input poll_mask_t p, input time_ms_t t);
        in_valid <= 1'b1;
        pressed  <= p;
        now_ms   <= t;
        do
            @(posedge clk);
        while (!in_ready);
        expected_masks_q.push_back(predict_poll(p, t));
        polls_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_masks_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input time_ms_t w);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_ms = w;
        window_writes++;
    endtask

    task automatic random_polls(input int count);
        int         kind;
        int         span;
        poll_mask_t flip;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            span = (window_ms > 1000) ? 1000 : int'(window_ms);
            if (kind < 8)
            begin
                // noise: arbitrary buttons, arbitrary time
                stim_pressed = poll_mask_t'($urandom);
                stim_now = $urandom;
            end
            else
            begin
                flip = poll_mask_t'($urandom & $urandom & $urandom);
                stim_pressed ^= flip;
                if (kind < 60)
                    stim_now += $urandom_range(0, span / 4 + 1);
                else if (kind < 85)
                    stim_now += $urandom_range(0, span + span / 2 + 2);
                else if (kind < 95)
                    stim_now += 0;
                else
                    stim_now += $urandom;
            end
            if (n == count / 2)
                drain_results();
            send_poll(stim_pressed, stim_now);
        end
    endtask

    // Edges, held state, double clicks at the window edge and across time wrap
    task automatic test_default_window();
        send_poll(8'h00, 32'd100);
        send_poll(8'h01, 32'd100);
        send_poll(8'h00, 32'd150);
        send_poll(8'h01, 32'd300);
        send_poll(8'h00, 32'd600);           // release exactly at the window
        send_poll(8'h01, 32'd700);
        send_poll(8'h00, 32'd750);
        send_poll(8'h01, 32'd900);
        send_poll(8'h00, 32'd1201);          // one past the window: plain up
        send_poll(8'h02, 32'd2000);
        send_poll(8'h00, 32'd2100);
        send_poll(8'h02, 32'd2500);          // second press at the window restarts
        send_poll(8'h00, 32'd2600);
        send_poll(8'hFF, 32'd3000);
        send_poll(8'hFF, 32'd3001);
        send_poll(8'h00, 32'd3002);
        send_poll(8'h80, 32'hFFFF_FFF0);
        send_poll(8'h00, 32'hFFFF_FFF8);
        send_poll(8'h80, 32'h0000_0010);     // time wrapped between clicks
        send_poll(8'h00, 32'h0000_0020);
        send_poll(8'hAA, 32'hFFFF_FFFF);
        send_poll(8'h55, 32'h0000_0000);
        send_poll(8'h04, 32'd5000);
        send_poll(8'h00, 32'd5600);          // slow release drops the first click
        send_poll(8'h04, 32'd5610);
        stim_pressed = 8'h04;
        stim_now = 32'd5610;
    endtask

    task automatic test_window_extremes();
        write_window(32'd0);
        send_poll(8'h00, 32'd7000);
        send_poll(8'h0F, 32'd7000);
        send_poll(8'h00, 32'd7000);
        send_poll(8'h0F, 32'd7000);
        send_poll(8'h00, 32'd7000);
        stim_pressed = 8'h00;
        stim_now = 32'd7000;
        random_polls(40);
        write_window(32'hFFFF_FFFF);
        send_poll(8'hF0, 32'd10);
        send_poll(8'h00, 32'h8000_0000);
        send_poll(8'hF0, 32'hFFFF_FFF0);
        send_poll(8'h00, 32'd9);
        stim_pressed = 8'h00;
        stim_now = 32'd9;
        random_polls(40);
        write_window(32'd1);
        random_polls(40);
    endtask

    task automatic test_random_polls();
        time_ms_t windows[5];
        windows[0] = WINDOW_RESET;
        windows[1] = 32'd37;
        windows[2] = 32'd0;
        windows[3] = 32'hFFFF_FFFF;
        windows[4] = $urandom_range(1, 2000);
        for (int ph = 0; ph < 5; ph++)
        begin
            write_window(windows[ph]);
            random_polls(256);
        end
    endtask

    initial
    begin
        int wait_cycles;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            clicks[i] = CLICK_NONE;
            first_press_ms[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_window_extremes();
        test_random_polls();

        in_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_masks_q.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        mismatch_count += expected_masks_q.size();

        $display("covered %0d polls and %0d checked results, %0d with double clicks",
                 polls_sent, masks_checked, doubles_seen);
        $display("window written %0d times, extremes 0 and all ones included; %0d errors",
                 window_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
